[rtl/rtcp_pkg.sv]
// Shared types and constants for the RTCP compound packet parser.
package rtcp_pkg;

  localparam logic [15:0] MAX_PACKET_BYTES = 16'hFFFF;
  localparam logic [7:0]  PT_SDES  = 8'd202;
  localparam logic [7:0]  PT_GENERIC_FB = 8'd205;
  localparam logic [7:0]  PT_PSFB  = 8'd206;
  localparam logic [4:0]  FMT_MASK = 5'h1F;
  localparam logic [4:0]  FMT_ONE  = 5'd1;
  localparam logic [4:0]  NACK_LAST_OFF = 5'd15;
  localparam logic [4:0]  PLI_LAST_OFF  = 5'd11;
  localparam int          QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    EV_NACK  = 2'd0,
    EV_PLI   = 2'd1,
    EV_CNAME = 2'd2,
    EV_TRUNC = 2'd3
  } event_kind_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        packet_start;
    logic [15:0] packet_bytes;
  } byte_req_t;

  typedef struct packed {
    event_kind_t kind;
    logic [31:0] source_id;
    logic [15:0] first_lost_seq;
    logic [15:0] lost_bitmask;
    logic [7:0]  name_byte;
    logic        name_first;
    logic        name_last;
    logic [7:0]  packet_type;
  } event_t;

endpackage

[rtl/rtcp_queue.sv]
// Two-entry request queue between the byte front end and the parser.
module rtcp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_valid,
  output logic               wr_ready,
  input  rtcp_pkg::byte_req_t wr_data,
  output logic               rd_valid,
  input  logic               rd_ready,
  output rtcp_pkg::byte_req_t rd_data
);
  import rtcp_pkg::*;

  byte_req_t mem_r [QUEUE_DEPTH];
  logic      wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic      push, pop;

  assign wr_ready = (count_r != 2'(QUEUE_DEPTH));
  assign rd_valid = (count_r != 2'd0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign push = wr_valid && wr_ready;
  assign pop  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

[rtl/rtcp_parse.sv]
// Back end: walks sub-packet headers and produces one event per byte at most.
module rtcp_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  output logic                req_ready,
  input  rtcp_pkg::byte_req_t req,
  output logic                ev_valid,
  input  logic                ev_ready,
  output rtcp_pkg::event_t    ev
);
  import rtcp_pkg::*;

  typedef enum logic [1:0] {PH_TYPE, PH_LEN, PH_VALUE, PH_STOP} phase_t;

  logic [15:0] pkt_left_r, pkt_left_nxt;
  logic [17:0] sub_left_r, sub_left_nxt;
  logic [17:0] sub_off_r, sub_off_nxt;
  logic [31:0] header_r, header_nxt;
  logic [31:0] chunk_ssrc_r, chunk_ssrc_nxt;
  logic [31:0] media_ssrc_r, media_ssrc_nxt;
  logic [31:0] nack_r, nack_nxt;
  phase_t      phase_r, phase_nxt;
  logic        is_cname_r, is_cname_nxt;
  logic [7:0]  item_left_r, item_left_nxt;
  logic        at_first_r, at_first_nxt;
  logic        halted_r, halted_nxt;
  logic        ev_valid_r;
  event_t      ev_r, ev_nxt;
  logic        emit;
  logic        step;

  logic [15:0] pkt_left_v;
  logic [17:0] sub_len;
  logic [18:0] avail;
  logic [7:0]  b, pt;
  logic [4:0]  fmt;
  logic [17:0] sub_left_dec;

  assign req_ready = !ev_valid_r || ev_ready;
  assign step = req_valid && req_ready;
  assign ev_valid = ev_valid_r;
  assign ev = ev_r;
  assign b  = req.data_byte;
  assign pt = header_r[23:16];
  assign fmt = header_r[28:24] & FMT_MASK;

  always_comb begin
    pkt_left_nxt = pkt_left_r;
    sub_left_nxt = sub_left_r;
    sub_off_nxt = sub_off_r;
    header_nxt = header_r;
    chunk_ssrc_nxt = chunk_ssrc_r;
    media_ssrc_nxt = media_ssrc_r;
    nack_nxt = nack_r;
    phase_nxt = phase_r;
    is_cname_nxt = is_cname_r;
    item_left_nxt = item_left_r;
    at_first_nxt = at_first_r;
    halted_nxt = halted_r;
    emit = 1'b0;
    ev_nxt = '0;
    sub_len = '0;
    avail = '0;
    sub_left_dec = '0;
    pkt_left_v = pkt_left_r;
    if (req.packet_start) begin
      pkt_left_v = (req.packet_bytes > MAX_PACKET_BYTES) ? MAX_PACKET_BYTES
                                                          : req.packet_bytes;
      pkt_left_nxt = pkt_left_v;
      sub_off_nxt = '0;
      sub_left_nxt = '0;
      header_nxt = '0;
      halted_nxt = (pkt_left_v == 16'd0);
    end
    if (!halted_nxt && pkt_left_v != 16'd0) begin
      if (sub_off_nxt == 18'd0 && pkt_left_v < 16'd4) begin
        halted_nxt = 1'b1;
      end else begin
        if (sub_off_nxt < 18'd4) begin
          header_nxt = {header_nxt[23:0], b};
          if (sub_off_nxt < 18'd3) begin
            sub_off_nxt = sub_off_nxt + 18'd1;
          end else begin
            sub_len = {header_nxt[15:0], 2'b00} + 18'd4;
            avail = {3'b0, pkt_left_v} + 19'd3;
            if (header_nxt[15:0] == 16'hFFFF || {1'b0, sub_len} > avail) begin
              emit = 1'b1;
              ev_nxt.kind = EV_TRUNC;
              ev_nxt.packet_type = header_nxt[23:16];
              halted_nxt = 1'b1;
            end else begin
              sub_left_nxt = sub_len - 18'd4;
              phase_nxt = PH_TYPE;
              item_left_nxt = '0;
              at_first_nxt = 1'b0;
              sub_off_nxt = (sub_left_nxt == 18'd0) ? 18'd0 : 18'd4;
            end
          end
        end else begin
          if (pt == PT_SDES) begin
            if (sub_off_r < 18'd8) begin
              chunk_ssrc_nxt = {chunk_ssrc_r[23:0], b};
            end else begin
              case (phase_r)
                PH_TYPE: begin
                  if (sub_left_r < 18'd2 || b == 8'd0) begin
                    phase_nxt = PH_STOP;
                  end else begin
                    is_cname_nxt = (b == 8'd1);
                    phase_nxt = PH_LEN;
                  end
                end
                PH_LEN: begin
                  if ({10'd0, b} + 18'd1 > sub_left_r) phase_nxt = PH_STOP;
                  else if (b == 8'd0) phase_nxt = PH_TYPE;
                  else begin
                    item_left_nxt = b;
                    at_first_nxt = 1'b1;
                    phase_nxt = PH_VALUE;
                  end
                end
                PH_VALUE: begin
                  if (is_cname_r) begin
                    emit = 1'b1;
                    ev_nxt.kind = EV_CNAME;
                    ev_nxt.source_id = chunk_ssrc_r;
                    ev_nxt.name_byte = b;
                    ev_nxt.name_first = at_first_r;
                    ev_nxt.name_last = (item_left_r == 8'd1);
                    ev_nxt.packet_type = PT_SDES;
                  end
                  at_first_nxt = 1'b0;
                  if (item_left_r <= 8'd1) begin
                    item_left_nxt = '0;
                    phase_nxt = PH_TYPE;
                  end else begin
                    item_left_nxt = item_left_r - 8'd1;
                  end
                end
                default: ;
              endcase
            end
          end else if ((pt == PT_GENERIC_FB || pt == PT_PSFB) && fmt == FMT_ONE) begin
            if (sub_off_r >= 18'd8 && sub_off_r < 18'd12)
              media_ssrc_nxt = {media_ssrc_r[23:0], b};
            else if (sub_off_r >= 18'd12 && sub_off_r < 18'd16)
              nack_nxt = {nack_r[23:0], b};
            if (pt == PT_PSFB && sub_off_r == {13'd0, PLI_LAST_OFF}) begin
              emit = 1'b1;
              ev_nxt.kind = EV_PLI;
              ev_nxt.source_id = media_ssrc_nxt;
              ev_nxt.packet_type = pt;
            end else if (pt == PT_GENERIC_FB && sub_off_r == {13'd0, NACK_LAST_OFF}) begin
              emit = 1'b1;
              ev_nxt.kind = EV_NACK;
              ev_nxt.source_id = media_ssrc_r;
              ev_nxt.first_lost_seq = nack_nxt[31:16];
              ev_nxt.lost_bitmask = nack_nxt[15:0];
              ev_nxt.packet_type = pt;
            end
          end
          sub_left_dec = (sub_left_r != 18'd0) ? sub_left_r - 18'd1 : 18'd0;
          sub_left_nxt = sub_left_dec;
          sub_off_nxt = (sub_left_dec == 18'd0) ? 18'd0 : sub_off_r + 18'd1;
        end
        if (!emit || ev_nxt.kind != EV_TRUNC) begin
          pkt_left_nxt = pkt_left_v - 16'd1;
          if (pkt_left_v == 16'd1) halted_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_left_r <= '0;
      sub_left_r <= '0;
      sub_off_r <= '0;
      header_r <= '0;
      chunk_ssrc_r <= '0;
      media_ssrc_r <= '0;
      nack_r <= '0;
      phase_r <= PH_TYPE;
      is_cname_r <= 1'b0;
      item_left_r <= '0;
      at_first_r <= 1'b0;
      halted_r <= 1'b1;
      ev_valid_r <= 1'b0;
    end else begin
      ev_valid_r <= step ? emit : (ev_valid_r && !ev_ready);
      if (step) begin
        pkt_left_r <= pkt_left_nxt;
        sub_left_r <= sub_left_nxt;
        sub_off_r <= sub_off_nxt;
        header_r <= header_nxt;
        chunk_ssrc_r <= chunk_ssrc_nxt;
        media_ssrc_r <= media_ssrc_nxt;
        nack_r <= nack_nxt;
        phase_r <= phase_nxt;
        is_cname_r <= is_cname_nxt;
        item_left_r <= item_left_nxt;
        at_first_r <= at_first_nxt;
        halted_r <= halted_nxt;
      end
    end
    if (step && emit) ev_r <= ev_nxt;
  end

endmodule

[rtl/rtcp_compound_feedback_parser.sv]
// Top level of the RTCP compound packet parser.
// Bytes of a compound RTCP packet enter on the in_ channel, one request per
// byte; in_packet_start flags the first byte and in_packet_bytes gives the
// total length on that byte. Events leave on the out_ channel: NACK, PLI,
// CNAME byte or truncated sub-packet, at most one per byte.
// A two-entry queue holds bytes ahead of the parser, so the block takes one
// byte per cycle while the receiver keeps up. On its way to out_, a byte is
// first written into the queue, and the parser then registers its event in
// the output register when it takes the byte from the queue. The parser
// takes one byte per cycle while its output is not stalled.
// When the receiver stalls, the output register holds the event, the parser
// holds, and the queue fills; in_ready drops once both entries are taken.
// Reset empties the queue, drops any pending event and leaves the parser idle
// until the next flagged first byte.
module rtcp_compound_feedback_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_packet_start,
  input  logic [15:0] in_packet_bytes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_event_kind,
  output logic [31:0] out_source_id,
  output logic [15:0] out_first_lost_seq,
  output logic [15:0] out_lost_bitmask,
  output logic [7:0]  out_name_byte,
  output logic        out_name_first,
  output logic        out_name_last,
  output logic [7:0]  out_packet_type
);
  import rtcp_pkg::*;

  byte_req_t in_req, q_req;
  logic      q_valid, q_ready;
  event_t    ev;

  assign in_req.data_byte    = in_data_byte;
  assign in_req.packet_start = in_packet_start;
  assign in_req.packet_bytes = in_packet_bytes;

  rtcp_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(in_valid), .wr_ready(in_ready), .wr_data(in_req),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_req)
  );

  rtcp_parse u_parse (
    .clk(clk), .rst_n(rst_n),
    .req_valid(q_valid), .req_ready(q_ready), .req(q_req),
    .ev_valid(out_valid), .ev_ready(out_ready), .ev(ev)
  );

  assign out_event_kind     = ev.kind;
  assign out_source_id      = ev.source_id;
  assign out_first_lost_seq = ev.first_lost_seq;
  assign out_lost_bitmask   = ev.lost_bitmask;
  assign out_name_byte      = ev.name_byte;
  assign out_name_first     = ev.name_first;
  assign out_name_last      = ev.name_last;
  assign out_packet_type    = ev.packet_type;

endmodule
